// ===== hdl/mfbe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfbe_pkg
// Shared types and constants for the masked field bit extractor.
// ----------------------------------------------------------------------------
package mfbe_pkg;

  // width of the packed field that is kept
  localparam int VALUE_WIDTH = 64;
  localparam int PosW        = $clog2(VALUE_WIDTH + 1);
  localparam int SumW        = PosW + 1;

  // fixed port widths
  localparam int ByteW  = 8;
  localparam int CountW = 4;
  localparam int FieldW = 64;
  localparam int TakenW = 7;

  // queue between front and back
  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QLevelW    = $clog2(QueueDepth + 1);

  typedef enum logic {
    ORDER_LAST_LOW  = 1'b0,
    ORDER_FIRST_LOW = 1'b1
  } byte_order_e;

  // one compressed byte on its way to the back end
  typedef struct packed {
    logic [ByteW-1:0]  bits;
    logic [CountW-1:0] count;
    byte_order_e       order;
    logic              last;
  } entry_t;

endpackage

// ===== hdl/mfbe_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfbe_front
// Accepts message bytes, compresses the masked bits and tags each item with
// the byte order in force.
// ----------------------------------------------------------------------------
module mfbe_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_wdata_i,
  input  logic [7:0]             data_byte_i,
  input  logic [7:0]             mask_byte_i,
  input  logic                   last_byte_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   q_full_i,
  output logic                   q_push_o,
  output mfbe_pkg::entry_t       q_entry_o
);

  mfbe_pkg::byte_order_e order_q, order_d;
  logic [mfbe_pkg::ByteW-1:0]  bits;
  logic [mfbe_pkg::CountW-1:0] cnt;

  always_comb begin
    order_d = order_q;
    if (cfg_we_i) begin
      order_d = mfbe_pkg::byte_order_e'(cfg_wdata_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= mfbe_pkg::ORDER_LAST_LOW;
    end else begin
      order_q <= order_d;
    end
  end

  // gather selected bits, lsb first
  always_comb begin
    bits = '0;
    cnt  = '0;
    for (int k = 0; k < mfbe_pkg::ByteW; k++) begin
      if (mask_byte_i[k]) begin
        bits[cnt[2:0]] = data_byte_i[k];
        cnt            = cnt + 1'b1;
      end
    end
  end

  assign in_stall_o        = q_full_i;
  assign q_push_o          = in_valid_i & ~q_full_i;
  assign q_entry_o.bits    = bits;
  assign q_entry_o.count   = cnt;
  assign q_entry_o.order   = order_q;
  assign q_entry_o.last    = last_byte_i;

endmodule

// ===== hdl/mfbe_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfbe_queue
// Short first-in first-out queue of compressed items between front and back.
// ----------------------------------------------------------------------------
module mfbe_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  mfbe_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output mfbe_pkg::entry_t entry_o
);

  mfbe_pkg::entry_t                store_q [mfbe_pkg::QueueDepth];
  logic [mfbe_pkg::QPtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [mfbe_pkg::QPtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [mfbe_pkg::QLevelW-1:0]    level_q, level_d;

  assign full_o  = (level_q == mfbe_pkg::QLevelW'(mfbe_pkg::QueueDepth));
  assign empty_o = (level_q == '0);
  assign entry_o = store_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == mfbe_pkg::QPtrW'(mfbe_pkg::QueueDepth - 1)) ? '0
                                                                        : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == mfbe_pkg::QPtrW'(mfbe_pkg::QueueDepth - 1)) ? '0
                                                                        : rd_ptr_q + 1'b1;
    end
    unique case ({push_i, pop_i})
      2'b10:   level_d = level_q + 1'b1;
      2'b01:   level_d = level_q - 1'b1;
      default: level_d = level_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ===== hdl/mfbe_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfbe_back
// Merges compressed items into the field accumulator and holds the result
// item in an output register until it is taken.
// ----------------------------------------------------------------------------
module mfbe_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  mfbe_pkg::entry_t q_entry_i,
  output logic             q_pop_o,
  output logic [63:0]      field_value_o,
  output logic [6:0]       bits_taken_o,
  output logic             too_many_bits_o,
  output logic             out_valid_o,
  input  logic             out_stall_i
);

  logic [mfbe_pkg::VALUE_WIDTH-1:0] acc_q, acc_d, acc_m;
  logic [mfbe_pkg::PosW-1:0]        pos_q, pos_d, pos_m;
  logic                             ovf_q, ovf_d, ovf_m;
  logic [mfbe_pkg::SumW-1:0]        sum;
  logic                             over;

  logic                             out_valid_q, out_valid_d;
  logic [mfbe_pkg::VALUE_WIDTH-1:0] res_value_q;
  logic [mfbe_pkg::PosW-1:0]        res_taken_q;
  logic                             res_flag_q;
  logic                             take_last;

  // a last item needs the output register free (or leaving this cycle)
  assign q_pop_o   = ~q_empty_i & (~q_entry_i.last | ~out_valid_q | ~out_stall_i);
  assign take_last = q_pop_o & q_entry_i.last;

  always_comb begin
    sum   = {1'b0, pos_q} + mfbe_pkg::SumW'(q_entry_i.count);
    over  = (sum > mfbe_pkg::SumW'(mfbe_pkg::VALUE_WIDTH));
    pos_m = over ? mfbe_pkg::PosW'(mfbe_pkg::VALUE_WIDTH) : sum[mfbe_pkg::PosW-1:0];
    ovf_m = ovf_q | over;
    unique case (q_entry_i.order)
      mfbe_pkg::ORDER_FIRST_LOW: begin
        // shift past the end drops the bits that no longer fit
        acc_m = acc_q | (mfbe_pkg::VALUE_WIDTH'(q_entry_i.bits) << pos_q);
      end
      mfbe_pkg::ORDER_LAST_LOW: begin
        acc_m = (acc_q << q_entry_i.count) | mfbe_pkg::VALUE_WIDTH'(q_entry_i.bits);
      end
      default: acc_m = acc_q;
    endcase
  end

  always_comb begin
    acc_d       = acc_q;
    pos_d       = pos_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q & out_stall_i;
    if (q_pop_o) begin
      if (q_entry_i.last) begin
        acc_d       = '0;
        pos_d       = '0;
        ovf_d       = 1'b0;
        out_valid_d = 1'b1;
      end else begin
        acc_d = acc_m;
        pos_d = pos_m;
        ovf_d = ovf_m;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      pos_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      pos_q       <= pos_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_last) begin
      res_value_q <= acc_m;
      res_taken_q <= pos_m;
      res_flag_q  <= ovf_m;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign field_value_o   = 64'(res_value_q);
  assign bits_taken_o    = 7'(res_taken_q);
  assign too_many_bits_o = res_flag_q;

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= mfbe_pkg::PosW'(mfbe_pkg::VALUE_WIDTH))
    else $error("bit position past field width");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (pos_q == mfbe_pkg::PosW'(mfbe_pkg::VALUE_WIDTH)))
    else $error("overflow flagged with field not full");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_last |=> (pos_q == '0) && (acc_q == '0) && !ovf_q)
    else $error("state not cleared after last item");

  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_last |=> out_valid_o && (bits_taken_o == 7'($past(pos_m))))
    else $error("result item not presented after last item");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !take_last)
    else $error("held result item overwritten");

endmodule

// ===== hdl/masked_field_bit_extract.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_field_bit_extract
// Gathers masked bits of a byte stream into one packed field value.
// ----------------------------------------------------------------------------
// Input channel: one message byte with its mask byte and a last marker per
// item, taken when in_valid_i is high and in_stall_o is low.
// Output channel: one item per message (on the last byte) carrying the packed
// value, the number of bits taken (saturating at 64) and an overflow flag,
// taken when out_valid_o is high and out_stall_i is low.
// Config: cfg_we_i writes cfg_wdata_i into byte_order; 1 puts the first byte
// in the low bits, 0 puts the last byte in the low bits. Write while idle.
// Throughput: one byte per cycle while in_stall_o is low. The front compresses
// each byte and pushes it into a two-entry queue; the back merges one queue
// entry per cycle into the accumulator, one shift and or per cycle, unless a
// last entry waits for a held result. The last byte passes through the queue
// and is merged by the back into the result register, raising out_valid_o.
// When the output is stalled, a held result blocks only the next last byte;
// non-last bytes keep merging, and in_stall_o rises once the queue fills.
// Reset clears byte_order to 0, the accumulator, the queue pointers and out_valid_o.
// ----------------------------------------------------------------------------
module masked_field_bit_extract (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic [7:0]  data_byte_i,
  input  logic [7:0]  mask_byte_i,
  input  logic        last_byte_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  output logic [63:0] field_value_o,
  output logic [6:0]  bits_taken_o,
  output logic        too_many_bits_o,
  output logic        out_valid_o,
  input  logic        out_stall_i
);

  mfbe_pkg::entry_t push_entry, pop_entry;
  logic             q_push, q_pop, q_full, q_empty;

  mfbe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .data_byte_i (data_byte_i),
    .mask_byte_i (mask_byte_i),
    .last_byte_i (last_byte_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (push_entry)
  );

  mfbe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .entry_o (pop_entry)
  );

  mfbe_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_entry_i       (pop_entry),
    .q_pop_o         (q_pop),
    .field_value_o   (field_value_o),
    .bits_taken_o    (bits_taken_o),
    .too_many_bits_o (too_many_bits_o),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i)
  );

endmodule
